>>> rtl/njtb_pkg.sv
// ---------------------------------------------------------------------------
// Neighbour-joining tree builder package
// Shared widths, sequencer states and transaction structures.
// ---------------------------------------------------------------------------
`default_nettype none

package njtb_pkg;

	localparam int MAX_TAXA_DEF   = 32;
	localparam int DIST_WIDTH_DEF = 32;
	localparam int SCORE_W        = 40;
	localparam int LEN_W          = 32;
	localparam int LBL_W          = 6;
	localparam int IDX_W          = 5;
	localparam int DIN_W          = 31;
	localparam int TCNT_W         = 6;
	localparam logic [TCNT_W-1:0] TCNT_RST = 6'd32;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_LD_B,
		ST_INIT,
		ST_SC_ROW,
		ST_SC_RD,
		ST_SC_ACC,
		ST_SC_DIV,
		ST_SC_WAIT,
		ST_PK_ROW,
		ST_PK_RA,
		ST_PK_RD,
		ST_PK_RB,
		ST_PK_CMP,
		ST_JN_X,
		ST_JN_Y,
		ST_JN_RX,
		ST_JN_RY,
		ST_JN_OUT,
		ST_MG_P,
		ST_MG_1,
		ST_MG_2,
		ST_MG_W1,
		ST_MG_W2,
		ST_MG_END,
		ST_RT0,
		ST_RT1,
		ST_RT2,
		ST_RT3,
		ST_RT4,
		ST_RT5,
		ST_RT_OUT
	} njtb_state_t;

	typedef struct packed {
		logic                     kind;
		logic [LBL_W-1:0]         child_a;
		logic [LBL_W-1:0]         child_b;
		logic [LBL_W-1:0]         child_c;
		logic signed [LEN_W-1:0]  length_a;
		logic signed [LEN_W-1:0]  length_b;
		logic signed [LEN_W-1:0]  length_c;
		logic [LBL_W-1:0]         parent_label;
		logic                     last_result;
	} njtb_res_t;

	typedef struct packed {
		logic              start;
		logic [TCNT_W-1:0] divisor;
	} njtb_div_req_t;

endpackage

`default_nettype wire

>>> rtl/njtb_entry_if.sv
// ---------------------------------------------------------------------------
// Neighbour-joining entry channel
// Valid/ready channel carrying one distance matrix entry per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface njtb_entry_if;
	logic                            valid;
	logic                            ready;
	logic [njtb_pkg::IDX_W-1:0]      row_index;
	logic [njtb_pkg::IDX_W-1:0]      col_index;
	logic [njtb_pkg::DIN_W-1:0]      distance;
	logic                            last_entry;

	modport source (output valid, row_index, col_index, distance, last_entry, input ready);
	modport sink (input valid, row_index, col_index, distance, last_entry, output ready);
endinterface

`default_nettype wire

>>> rtl/njtb_result_if.sv
// ---------------------------------------------------------------------------
// Neighbour-joining result channel
// Valid/ready channel carrying one join or root result per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface njtb_result_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  kind;
	logic [njtb_pkg::LBL_W-1:0]            child_a;
	logic [njtb_pkg::LBL_W-1:0]            child_b;
	logic [njtb_pkg::LBL_W-1:0]            child_c;
	logic signed [njtb_pkg::LEN_W-1:0]     length_a;
	logic signed [njtb_pkg::LEN_W-1:0]     length_b;
	logic signed [njtb_pkg::LEN_W-1:0]     length_c;
	logic [njtb_pkg::LBL_W-1:0]            parent_label;
	logic                                  last_result;

	modport source (output valid, kind, child_a, child_b, child_c, length_a, length_b,
		length_c, parent_label, last_result, input ready);
	modport sink (input valid, kind, child_a, child_b, child_c, length_a, length_b,
		length_c, parent_label, last_result, output ready);
endinterface

`default_nettype wire

>>> rtl/njtb_cfg_if.sv
// ---------------------------------------------------------------------------
// Neighbour-joining configuration channel
// Valid/ready write channel for the taxa count register.
// ---------------------------------------------------------------------------
`default_nettype none

interface njtb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [njtb_pkg::TCNT_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/njtb_div.sv
// ---------------------------------------------------------------------------
// Neighbour-joining row score divider
// Bit-serial restoring divider, truncating toward zero, saturated to score width.
// ---------------------------------------------------------------------------
`default_nettype none

module njtb_div #(
	parameter int ACC_W = 38
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire njtb_pkg::njtb_div_req_t             req,
	input  wire logic signed [ACC_W-1:0]             dividend,
	output logic                                     done,
	output logic signed [njtb_pkg::SCORE_W-1:0]      quotient
);
	import njtb_pkg::*;

	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam logic signed [63:0] Q_MAX = (64'sd1 <<< (SCORE_W - 1)) - 64'sd1;
	localparam logic signed [63:0] Q_MIN = -(64'sd1 <<< (SCORE_W - 1));

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_q;
	logic [ACC_W-1:0]     dvd_q;
	logic [TCNT_W-1:0]    rem_q;
	logic [TCNT_W-1:0]    dsr_q;
	logic [TCNT_W:0]      shifted;
	logic [TCNT_W:0]      trial;
	logic                 fits;
	logic signed [63:0]   qx;

	assign shifted = {rem_q, dvd_q[ACC_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign fits    = (shifted >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= dividend[ACC_W-1];
			dvd_q <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[TCNT_W-1:0] : shifted[TCNT_W-1:0];
			dvd_q <= {dvd_q[ACC_W-2:0], fits};
		end
	end

	always_comb begin
		qx = neg_q ? -$signed(64'(dvd_q)) : $signed(64'(dvd_q));
		if (qx > Q_MAX) begin
			quotient = SCORE_W'(Q_MAX);
		end else if (qx < Q_MIN) begin
			quotient = SCORE_W'(Q_MIN);
		end else begin
			quotient = SCORE_W'(qx);
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

>>> rtl/njtb_core.sv
// ---------------------------------------------------------------------------
// Neighbour-joining sequencer and datapath
// Distance memory, active list, scores and the joining sequence.
// ---------------------------------------------------------------------------
`default_nettype none

module njtb_core #(
	parameter int MAX_TAXA   = 32,
	parameter int DIST_WIDTH = 32,
	parameter int ACC_W      = 38
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	njtb_entry_if.sink                               entry,
	input  wire logic [njtb_pkg::TCNT_W-1:0]         taxa_count,
	output njtb_pkg::njtb_div_req_t                  div_req,
	output logic signed [ACC_W-1:0]                  div_dividend,
	input  wire logic                                div_done,
	input  wire logic signed [njtb_pkg::SCORE_W-1:0] div_quotient,
	input  wire logic                                res_free,
	output logic                                     res_load,
	output njtb_pkg::njtb_res_t                      res
);
	import njtb_pkg::*;

	localparam int IW  = $clog2(MAX_TAXA);
	localparam int CNW = $clog2(MAX_TAXA + 1);
	localparam int AD  = 2 * IW;
	localparam int DW  = DIST_WIDTH;
	localparam int CW  = ((DW > SCORE_W) ? DW : SCORE_W) + 4;
	localparam logic signed [CW-1:0] LEN_MAX = CW'((64'sd1 <<< (LEN_W - 1)) - 64'sd1);
	localparam logic signed [CW-1:0] LEN_MIN = CW'(-(64'sd1 <<< (LEN_W - 1)));
	localparam logic signed [CW-1:0] DW_MAX  = CW'((64'sd1 <<< (DW - 1)) - 64'sd1);
	localparam logic signed [CW-1:0] DW_MIN  = CW'(-(64'sd1 <<< (DW - 1)));
	localparam logic [63:0]          LD_MAX  = (64'd1 << (DW - 1)) - 64'd1;

	function automatic logic signed [LEN_W-1:0] sat_len(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] h;
		h = v >>> 1;
		if (h > LEN_MAX) return LEN_W'(LEN_MAX);
		if (h < LEN_MIN) return LEN_W'(LEN_MIN);
		return LEN_W'(h);
	endfunction

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] h;
		h = v >>> 1;
		if (h > DW_MAX) return DW'(DW_MAX);
		if (h < DW_MIN) return DW'(DW_MIN);
		return DW'(h);
	endfunction

	njtb_state_t state_q, state_d;

	logic signed [DW-1:0]      mem [0:(1 << AD)-1];
	logic signed [DW-1:0]      rd_q;
	logic                      rdz_q;
	logic [IW-1:0]             ord_q [0:MAX_TAXA-1];
	logic [LBL_W-1:0]          lbl_q [0:MAX_TAXA-1];
	logic signed [SCORE_W-1:0] scr_q [0:MAX_TAXA-1];

	logic [CNW-1:0]            p_q, q_q, k_q, cnt_q, n_q, ba_q, bb_q;
	logic [LBL_W-1:0]          jc_q;
	logic [IW-1:0]             sa_q, sb_q, u_q;
	logic [IDX_W-1:0]          ldr_q, ldc_q;
	logic                      ldok_q, ldlast_q;
	logic signed [DW-1:0]      ldd_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [SCORE_W-1:0] ra_q, rb_q, rc_q;
	logic signed [CW-1:0]      best_q;
	logic                      have_q;
	logic signed [DW-1:0]      dxy_q, d1_q, d2_q;
	logic [LBL_W-1:0]          la_q, lb_q, lc_q;

	logic [CNW-1:0]            n_clamp;
	logic                      in_ok;
	logic signed [DW-1:0]      in_d;
	logic signed [DW-1:0]      dval;
	logic signed [CW-1:0]      crit, dxdy;
	logic                      better;
	logic                      we;
	logic [AD-1:0]             waddr;
	logic signed [DW-1:0]      wdata;
	logic                      rd_en;
	logic [IW-1:0]             rd_row, rd_col;
	logic [CNW-1:0]            ord_idx;
	logic [IW-1:0]             ord_rd;
	logic [IW-1:0]             slot_idx;
	logic signed [SCORE_W-1:0] scr_rd;
	logic [LBL_W-1:0]          lbl_rd;
	logic [LBL_W-1:0]          parent;

	always_comb begin
		if (taxa_count < TCNT_W'(3)) begin
			n_clamp = CNW'(3);
		end else if (32'(taxa_count) > MAX_TAXA) begin
			n_clamp = CNW'(MAX_TAXA);
		end else begin
			n_clamp = CNW'(taxa_count);
		end
	end

	assign in_ok = (entry.row_index != entry.col_index)
		&& (32'(entry.row_index) < MAX_TAXA) && (32'(entry.col_index) < MAX_TAXA);
	assign in_d  = (64'(entry.distance) > LD_MAX) ? DW'(LD_MAX) : DW'(64'(entry.distance));
	assign dval  = rdz_q ? '0 : rd_q;
	assign ord_rd = ord_q[ord_idx[IW-1:0]];
	assign scr_rd = scr_q[slot_idx];
	assign lbl_rd = lbl_q[slot_idx];
	assign crit  = CW'(dval) - CW'(ra_q) - CW'(rb_q);
	assign better = !have_q || (crit < best_q);
	assign dxdy  = CW'(ra_q) - CW'(rb_q);
	assign parent = LBL_W'(n_q) + jc_q;
	assign entry.ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (entry.valid) state_d = ST_LD_B;
			ST_LD_B:    state_d = ldlast_q ? ST_INIT : ST_IDLE;
			ST_INIT:    if (p_q == n_q - 1'b1) state_d = ST_SC_ROW;
			ST_SC_ROW:  state_d = ST_SC_RD;
			ST_SC_RD:   state_d = ST_SC_ACC;
			ST_SC_ACC:  state_d = (q_q == cnt_q - 1'b1) ? ST_SC_DIV : ST_SC_RD;
			ST_SC_DIV:  state_d = ST_SC_WAIT;
			ST_SC_WAIT: begin
				if (div_done) begin
					if (p_q != cnt_q - 1'b1) begin
						state_d = ST_SC_ROW;
					end else if (cnt_q > CNW'(3)) begin
						state_d = ST_PK_ROW;
					end else begin
						state_d = ST_RT0;
					end
				end
			end
			ST_PK_ROW:  state_d = ST_PK_RA;
			ST_PK_RA:   state_d = ST_PK_RD;
			ST_PK_RD:   state_d = ST_PK_RB;
			ST_PK_RB:   state_d = ST_PK_CMP;
			ST_PK_CMP: begin
				if (q_q != cnt_q - 1'b1) begin
					state_d = ST_PK_RD;
				end else if (p_q == cnt_q - CNW'(2)) begin
					state_d = ST_JN_X;
				end else begin
					state_d = ST_PK_ROW;
				end
			end
			ST_JN_X:    state_d = ST_JN_Y;
			ST_JN_Y:    state_d = ST_JN_RX;
			ST_JN_RX:   state_d = ST_JN_RY;
			ST_JN_RY:   state_d = ST_JN_OUT;
			ST_JN_OUT:  if (res_free) state_d = ST_MG_P;
			ST_MG_P: begin
				if (p_q == cnt_q) begin
					state_d = ST_MG_END;
				end else if (p_q != ba_q && p_q != bb_q) begin
					state_d = ST_MG_1;
				end
			end
			ST_MG_1:    state_d = ST_MG_2;
			ST_MG_2:    state_d = ST_MG_W1;
			ST_MG_W1:   state_d = ST_MG_W2;
			ST_MG_W2:   state_d = ST_MG_P;
			ST_MG_END:  state_d = ST_SC_ROW;
			ST_RT0:     state_d = ST_RT1;
			ST_RT1:     state_d = ST_RT2;
			ST_RT2:     state_d = ST_RT3;
			ST_RT3:     state_d = ST_RT4;
			ST_RT4:     state_d = ST_RT5;
			ST_RT5:     state_d = ST_RT_OUT;
			ST_RT_OUT:  if (res_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we       = 1'b0;
		waddr    = '0;
		wdata    = '0;
		rd_en    = 1'b0;
		rd_row   = sa_q;
		rd_col   = ord_rd;
		ord_idx  = p_q;
		slot_idx = sa_q;
		div_req.start   = 1'b0;
		div_req.divisor = TCNT_W'(cnt_q - CNW'(2));
		div_dividend    = acc_q;
		res_load = 1'b0;
		res      = '0;
		case (state_q)
			ST_IDLE: begin
				we    = entry.valid && in_ok;
				waddr = {entry.row_index[IW-1:0], entry.col_index[IW-1:0]};
				wdata = in_d;
			end
			ST_LD_B: begin
				we    = ldok_q;
				waddr = {ldc_q[IW-1:0], ldr_q[IW-1:0]};
				wdata = ldd_q;
			end
			ST_SC_RD: begin
				rd_en   = 1'b1;
				ord_idx = q_q;
			end
			ST_SC_DIV:  div_req.start = 1'b1;
			ST_PK_RD: begin
				rd_en   = 1'b1;
				ord_idx = q_q;
			end
			ST_PK_RB:   slot_idx = sb_q;
			ST_JN_X:    ord_idx = ba_q;
			ST_JN_Y: begin
				rd_en   = 1'b1;
				ord_idx = bb_q;
			end
			ST_JN_RY:   slot_idx = sb_q;
			ST_JN_OUT: begin
				res_load         = res_free;
				res.kind         = 1'b0;
				res.child_a      = la_q;
				res.child_b      = lb_q;
				res.length_a     = sat_len(CW'(dxy_q) + dxdy);
				res.length_b     = sat_len(CW'(dxy_q) - dxdy);
				res.parent_label = parent;
				res.last_result  = 1'b0;
			end
			ST_MG_P:    rd_en = 1'b1;
			ST_MG_1: begin
				rd_en  = 1'b1;
				rd_row = sb_q;
				rd_col = u_q;
			end
			ST_MG_W1: begin
				we    = 1'b1;
				waddr = {sa_q, u_q};
				wdata = sat_dw(CW'(acc_q));
			end
			ST_MG_W2: begin
				we    = 1'b1;
				waddr = {u_q, sa_q};
				wdata = sat_dw(CW'(acc_q));
			end
			ST_RT0:     ord_idx = '0;
			ST_RT1:     ord_idx = CNW'(1);
			ST_RT2: begin
				ord_idx  = CNW'(2);
				slot_idx = sb_q;
				rd_en    = 1'b1;
				rd_row   = sb_q;
			end
			ST_RT3: begin
				slot_idx = u_q;
				rd_en    = 1'b1;
				rd_row   = u_q;
				rd_col   = sa_q;
			end
			ST_RT4: begin
				rd_en  = 1'b1;
				rd_row = sa_q;
				rd_col = sb_q;
			end
			ST_RT_OUT: begin
				res_load         = res_free;
				res.kind         = 1'b1;
				res.child_a      = la_q;
				res.child_b      = lb_q;
				res.child_c      = lc_q;
				res.length_a     = sat_len(CW'(ra_q) - CW'(dxy_q));
				res.length_b     = sat_len(CW'(rb_q) - CW'(d1_q));
				res.length_c     = sat_len(CW'(rc_q) - CW'(d2_q));
				res.parent_label = parent;
				res.last_result  = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q  <= mem[{rd_row, rd_col}];
			rdz_q <= (rd_row == rd_col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= '0;
			q_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			jc_q    <= '0;
			have_q  <= 1'b0;
			ba_q    <= '0;
			bb_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LD_B: begin
					p_q <= '0;
					n_q <= n_clamp;
				end
				ST_INIT: begin
					p_q <= p_q + 1'b1;
					if (p_q == n_q - 1'b1) begin
						p_q   <= '0;
						cnt_q <= n_q;
						jc_q  <= '0;
					end
				end
				ST_SC_ROW:  q_q <= '0;
				ST_SC_ACC:  q_q <= q_q + 1'b1;
				ST_SC_WAIT: begin
					if (div_done) begin
						p_q <= (p_q == cnt_q - 1'b1) ? '0 : p_q + 1'b1;
						have_q <= 1'b0;
					end
				end
				ST_PK_ROW:  q_q <= p_q + 1'b1;
				ST_PK_CMP: begin
					if (better) begin
						have_q <= 1'b1;
						ba_q   <= p_q;
						bb_q   <= q_q;
					end
					if (q_q != cnt_q - 1'b1) begin
						q_q <= q_q + 1'b1;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_JN_OUT: begin
					p_q <= '0;
					k_q <= '0;
				end
				ST_MG_P:    if (p_q != cnt_q && (p_q == ba_q || p_q == bb_q)) p_q <= p_q + 1'b1;
				ST_MG_W1:   k_q <= k_q + 1'b1;
				ST_MG_W2:   p_q <= p_q + 1'b1;
				ST_MG_END: begin
					cnt_q <= k_q + 1'b1;
					jc_q  <= jc_q + 1'b1;
					p_q   <= '0;
				end
				default: begin
					have_q <= have_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ldr_q    <= entry.row_index;
				ldc_q    <= entry.col_index;
				ldd_q    <= in_d;
				ldok_q   <= in_ok;
				ldlast_q <= entry.last_entry;
			end
			ST_INIT: begin
				ord_q[p_q[IW-1:0]] <= p_q[IW-1:0];
				lbl_q[p_q[IW-1:0]] <= LBL_W'(p_q);
			end
			ST_SC_ROW: begin
				sa_q  <= ord_rd;
				acc_q <= '0;
			end
			ST_SC_ACC:  acc_q <= acc_q + ACC_W'(dval);
			ST_SC_WAIT: if (div_done) scr_q[sa_q] <= div_quotient;
			ST_PK_ROW:  sa_q <= ord_rd;
			ST_PK_RA:   ra_q <= scr_rd;
			ST_PK_RD:   sb_q <= ord_rd;
			ST_PK_RB:   rb_q <= scr_rd;
			ST_PK_CMP:  if (better) best_q <= crit;
			ST_JN_X:    sa_q <= ord_rd;
			ST_JN_Y:    sb_q <= ord_rd;
			ST_JN_RX: begin
				ra_q  <= scr_rd;
				la_q  <= lbl_rd;
				dxy_q <= dval;
			end
			ST_JN_RY: begin
				rb_q <= scr_rd;
				lb_q <= lbl_rd;
			end
			ST_MG_P:    u_q <= ord_rd;
			ST_MG_1:    acc_q <= ACC_W'(dval);
			ST_MG_2:    acc_q <= acc_q + ACC_W'(dval) - ACC_W'(dxy_q);
			ST_MG_W1:   ord_q[k_q[IW-1:0]] <= u_q;
			ST_MG_END: begin
				ord_q[k_q[IW-1:0]] <= sa_q;
				lbl_q[sa_q]        <= parent;
			end
			ST_RT0:     sa_q <= ord_rd;
			ST_RT1: begin
				sb_q <= ord_rd;
				ra_q <= scr_rd;
				la_q <= lbl_rd;
			end
			ST_RT2: begin
				u_q  <= ord_rd;
				rb_q <= scr_rd;
				lb_q <= lbl_rd;
			end
			ST_RT3: begin
				rc_q  <= scr_rd;
				lc_q  <= lbl_rd;
				dxy_q <= dval;
			end
			ST_RT4:     d1_q <= dval;
			ST_RT5:     d2_q <= dval;
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/neighbor_joining_tree_builder_unit.sv
// ---------------------------------------------------------------------------
// Neighbour-joining tree builder
// Loads a symmetric distance matrix and emits the joins of the tree.
// ---------------------------------------------------------------------------
// Usage:
//   entry  : one matrix entry per transaction; each entry is stored at both
//            (row,col) and (col,row), the second copy in ST_LD_B with
//            entry.ready low. Diagonal and out-of-range entries are dropped.
//   cfg    : taxa count, to be written by the user only while the block is
//            idle; the block itself does not enforce this.
//   result : one transaction per join, then one root transaction flagged by
//            last_result.
//   After an entry with last_entry set, entry.ready stays low for the whole
//   joining run. The single bit-serial divider and the single read port of
//   the matrix memory set the pace: each row score waits on the divider,
//   and the matrix is read one entry at a time.
//   The result register holds a transaction until it is taken; the
//   sequencer waits on a full register. Reset empties it, returns to idle
//   and sets the taxa count to 32; the matrix contents are undefined
//   until loaded.
`default_nettype none

module neighbor_joining_tree_builder_unit #(
	parameter int MAX_TAXA   = njtb_pkg::MAX_TAXA_DEF,
	parameter int DIST_WIDTH = njtb_pkg::DIST_WIDTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	njtb_entry_if.sink  entry,
	njtb_cfg_if.sink    cfg,
	njtb_result_if.source result
);
	import njtb_pkg::*;

	localparam int ACC_W = DIST_WIDTH + $clog2(MAX_TAXA) + 1;

	logic [TCNT_W-1:0]         taxa_q;
	njtb_div_req_t             div_req;
	logic signed [ACC_W-1:0]   div_dividend;
	logic                      div_done;
	logic signed [SCORE_W-1:0] div_quotient;
	logic                      res_free;
	logic                      res_load;
	njtb_res_t                 res;
	njtb_res_t                 res_q;
	logic                      res_vld_q;

	assign cfg.ready = 1'b1;
	assign res_free  = !res_vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taxa_q    <= TCNT_RST;
			res_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				taxa_q <= cfg.data;
			end
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	njtb_core #(
		.MAX_TAXA   (MAX_TAXA),
		.DIST_WIDTH (DIST_WIDTH),
		.ACC_W      (ACC_W)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry        (entry),
		.taxa_count   (taxa_q),
		.div_req      (div_req),
		.div_dividend (div_dividend),
		.div_done     (div_done),
		.div_quotient (div_quotient),
		.res_free     (res_free),
		.res_load     (res_load),
		.res          (res)
	);

	njtb_div #(
		.ACC_W (ACC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign result.valid        = res_vld_q;
	assign result.kind         = res_q.kind;
	assign result.child_a      = res_q.child_a;
	assign result.child_b      = res_q.child_b;
	assign result.child_c      = res_q.child_c;
	assign result.length_a     = res_q.length_a;
	assign result.length_b     = res_q.length_b;
	assign result.length_c     = res_q.length_c;
	assign result.parent_label = res_q.parent_label;
	assign result.last_result  = res_q.last_result;

endmodule

`default_nettype wire

>>> rtl/njtb_chk.sv
// ---------------------------------------------------------------------------
// Neighbour-joining port checker
// Concurrent checks on the top-level channels, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module njtb_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        out_kind,
	input wire logic        out_last,
	input wire logic [5:0]  out_child_c,
	input wire logic [31:0] out_length_c
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_child_c)
			&& $stable(out_length_c) && $stable(out_kind))
		else $error("result transaction changed while stalled");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("entry accepted right after a last entry");

	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == out_last))
		else $error("root flag and kind disagree");

	a_join_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> (out_child_c == '0) && (out_length_c == '0))
		else $error("join transaction carries a third child");

endmodule

bind neighbor_joining_tree_builder_unit njtb_chk u_njtb_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (entry.valid),
	.in_ready     (entry.ready),
	.in_last      (entry.last_entry),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_kind     (result.kind),
	.out_last     (result.last_result),
	.out_child_c  (result.child_c),
	.out_length_c (result.length_c)
);

`default_nettype wire

>>> tb/neighbor_joining_tree_builder_unit_test.sv
// ---------------------------------------------------------------------------
// Neighbour-joining tree builder testbench
// Loads distance matrices over the entry channel at several taxa counts and
// predicts every join and root transaction with an independent model of the
// joining algorithm. Both channels idle at random, and results are checked
// in order, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module neighbor_joining_tree_builder_unit_test;
	import njtb_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
		logic [DIN_W-1:0] distance;
	} matrix_entry_t;

	class tree_scoreboard;
		longint dist_mat[MAX_TAXA_DEF][MAX_TAXA_DEF];
		bit known[MAX_TAXA_DEF][MAX_TAXA_DEF];
		int order[MAX_TAXA_DEF];
		int label[MAX_TAXA_DEF];
		longint rscore[MAX_TAXA_DEF];
		int n_act;
		int taxa = 32;
		int mismatches;
		int entries_seen;
		int results_seen;
		njtb_res_t joins_due[$];

		function void set_taxa(int v);
			taxa = v & 63;
		endfunction

		function longint sat(longint v, int w);
			longint hi;
			hi = (longint'(1) <<< (w - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function longint rd(int i, int j);
			if (i == j) return 0;
			return dist_mat[i][j];
		endfunction

		function void wr(int i, int j, longint v);
			if (i == j) return;
			dist_mat[i][j] = v;
			dist_mat[j][i] = v;
			known[i][j] = 1'b1;
			known[j][i] = 1'b1;
		endfunction

		function void rescore();
			longint s;
			longint dv;
			dv = n_act - 2;
			if (dv < 1) dv = 1;
			for (int p = 0; p < n_act; p++) begin
				s = 0;
				for (int q = 0; q < n_act; q++)
					s += rd(order[p], order[q]);
				rscore[order[p]] = sat(s / dv, SCORE_W);
			end
		endfunction

		function logic [LEN_W-1:0] len32(longint v);
			return LEN_W'(sat(v, LEN_W));
		endfunction

		function void build_tree();
			int n, joins, ba, bb, sx, sy, k;
			int rest[MAX_TAXA_DEF];
			longint best, v, dxy, dxdy;
			njtb_res_t r;
			n = taxa;
			if (n < 3) n = 3;
			if (n > MAX_TAXA_DEF) n = MAX_TAXA_DEF;
			for (int i = 0; i < n; i++) begin
				order[i] = i;
				label[i] = i;
			end
			n_act = n;
			joins = 0;
			rescore();
			while (n_act > 3) begin
				ba = 0;
				bb = 1;
				best = 0;
				for (int p = 0; p < n_act; p++)
					for (int q = p + 1; q < n_act; q++) begin
						v = rd(order[p], order[q]) - rscore[order[p]] - rscore[order[q]];
						if ((p == 0 && q == 1) || v < best) begin
							best = v;
							ba = p;
							bb = q;
						end
					end
				sx = order[ba];
				sy = order[bb];
				dxy = rd(sx, sy);
				dxdy = rscore[sx] - rscore[sy];
				r = '0;
				r.child_a = LBL_W'(label[sx]);
				r.child_b = LBL_W'(label[sy]);
				r.length_a = len32((dxy + dxdy) >>> 1);
				r.length_b = len32((dxy - dxdy) >>> 1);
				r.parent_label = LBL_W'(n + joins);
				joins_due.push_back(r);
				k = 0;
				for (int p = 0; p < n_act; p++)
					if (p != ba && p != bb) begin
						rest[k] = order[p];
						k++;
					end
				for (int p = 0; p < k; p++)
					wr(sx, rest[p], sat((rd(sx, rest[p]) + rd(sy, rest[p]) - dxy) >>> 1, 32));
				for (int p = 0; p < k; p++) order[p] = rest[p];
				order[k] = sx;
				n_act = k + 1;
				label[sx] = (n + joins) & 63;
				joins++;
				rescore();
			end
			r = '0;
			r.kind = 1'b1;
			r.child_a = LBL_W'(label[order[0]]);
			r.child_b = LBL_W'(label[order[1]]);
			r.child_c = LBL_W'(label[order[2]]);
			r.length_a = len32((rscore[order[0]] - rd(order[1], order[2])) >>> 1);
			r.length_b = len32((rscore[order[1]] - rd(order[2], order[0])) >>> 1);
			r.length_c = len32((rscore[order[2]] - rd(order[0], order[1])) >>> 1);
			r.parent_label = LBL_W'(n + joins);
			r.last_result = 1'b1;
			joins_due.push_back(r);
		endfunction

		function void note_entry(matrix_entry_t e, bit last);
			entries_seen++;
			if (e.row_index != e.col_index)
				wr(e.row_index, e.col_index, longint'(e.distance));
			if (last) build_tree();
		endfunction

		function void check_result(njtb_res_t got);
			njtb_res_t e;
			results_seen++;
			if (joins_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			e = joins_due.pop_front();
			if (got.kind !== e.kind || got.child_a !== e.child_a || got.child_b !== e.child_b
				|| got.child_c !== e.child_c || got.length_a !== e.length_a
				|| got.length_b !== e.length_b || got.length_c !== e.length_c
				|| got.parent_label !== e.parent_label || got.last_result !== e.last_result) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit quiet;
	int stall_cycles;
	tree_scoreboard sb;

	njtb_entry_if entry_ch();
	njtb_cfg_if cfg_ch();
	njtb_result_if result_ch();

	neighbor_joining_tree_builder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.entry(entry_ch),
		.cfg(cfg_ch),
		.result(result_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function bit idle_roll();
		return !quiet && $urandom_range(0, 99) < 27;
	endfunction

	always begin
		njtb_res_t got;
		bit took;
		@(negedge clk);
		took = result_ch.valid && result_ch.ready;
		got = '0;
		got.kind = result_ch.kind;
		got.child_a = result_ch.child_a;
		got.child_b = result_ch.child_b;
		got.child_c = result_ch.child_c;
		got.length_a = result_ch.length_a;
		got.length_b = result_ch.length_b;
		got.length_c = result_ch.length_c;
		got.parent_label = result_ch.parent_label;
		got.last_result = result_ch.last_result;
		@(posedge clk);
		if (took) sb.check_result(got);
		result_ch.ready <= !idle_roll();
	end

	always @(negedge clk) begin
		if ((entry_ch.valid && entry_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
			|| (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 400000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_entry(matrix_entry_t e, bit last);
		bit acc;
		while (idle_roll()) begin
			entry_ch.valid <= 1'b0;
			@(posedge clk);
		end
		entry_ch.valid <= 1'b1;
		entry_ch.row_index <= e.row_index;
		entry_ch.col_index <= e.col_index;
		entry_ch.distance <= e.distance;
		entry_ch.last_entry <= last;
		do begin
			@(negedge clk);
			acc = entry_ch.ready;
			@(posedge clk);
		end while (!acc);
		sb.note_entry(e, last);
	endtask

	task automatic write_taxa(int v);
		bit acc;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= TCNT_W'(v);
		do begin
			@(negedge clk);
			acc = cfg_ch.ready;
			@(posedge clk);
		end while (!acc);
		cfg_ch.valid <= 1'b0;
		sb.set_taxa(v);
	endtask

	task automatic drain();
		while (sb.joins_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function logic [DIN_W-1:0] pick_distance(int mode);
		case (mode)
			1: return '1;
			2: return DIN_W'($urandom_range(0, 3));
			3: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return '1;
					default: return DIN_W'($urandom);
				endcase
			end
			default: return DIN_W'($urandom_range(0, 32'h0010_0000));
		endcase
	endfunction

	task automatic run_phase(int taxa_value, int mode);
		matrix_entry_t plan[$];
		matrix_entry_t e, t;
		int n, j;
		drain();
		write_taxa(taxa_value);
		n = taxa_value & 63;
		if (n < 3) n = 3;
		if (n > MAX_TAXA_DEF) n = MAX_TAXA_DEF;
		for (int a = 0; a < n; a++)
			for (int b = a + 1; b < n; b++)
				if (!sb.known[a][b] || $urandom_range(0, 3) == 0) begin
					e.row_index = IDX_W'(($urandom_range(0, 1) != 0) ? a : b);
					e.col_index = IDX_W'((e.row_index == a) ? b : a);
					e.distance = pick_distance(mode);
					plan.push_back(e);
				end
		if (plan.size() == 0) begin
			e.row_index = 0;
			e.col_index = 1;
			e.distance = pick_distance(mode);
			plan.push_back(e);
		end
		repeat ($urandom_range(0, 3)) begin
			e.row_index = IDX_W'($urandom_range(0, 31));
			e.col_index = ($urandom_range(0, 1) != 0) ? e.row_index : IDX_W'($urandom_range(0, 31));
			e.distance = DIN_W'($urandom);
			plan.push_back(e);
		end
		for (int i = plan.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = plan[i];
			plan[i] = plan[j];
			plan[j] = t;
		end
		foreach (plan[i]) send_entry(plan[i], i == plan.size() - 1);
		entry_ch.valid <= 1'b0;
	endtask

	initial begin
		int phase_no;
		sb = new();
		arst_n = 1'b0;
		quiet = 1'b0;
		stall_cycles = 0;
		entry_ch.valid = 1'b0;
		entry_ch.row_index = '0;
		entry_ch.col_index = '0;
		entry_ch.distance = '0;
		entry_ch.last_entry = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_phase(0, 1);
		run_phase(3, 2);
		run_phase(2, 3);
		run_phase(4, 1);
		run_phase(1, 0);
		run_phase(5, 3);

		phase_no = 0;
		while (sb.entries_seen < 230) begin
			quiet = (phase_no >= 2 && phase_no < 6);
			run_phase($urandom_range(3, 9), $urandom_range(0, 3));
			phase_no++;
		end
		quiet = 1'b0;

		drain();
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.joins_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
rtl/njtb_pkg.sv
rtl/njtb_entry_if.sv
rtl/njtb_result_if.sv
rtl/njtb_cfg_if.sv
rtl/njtb_div.sv
rtl/njtb_core.sv
rtl/neighbor_joining_tree_builder_unit.sv
rtl/njtb_chk.sv
tb/neighbor_joining_tree_builder_unit_test.sv
